/* src/crc8_framed_packet_receiver_unit_defines.svh */
// Assertion macros for the checker file of the receiver.
`ifndef CRC8_FRAMED_PACKET_RECEIVER_UNIT_DEFINES_SVH
`define CRC8_FRAMED_PACKET_RECEIVER_UNIT_DEFINES_SVH

// Immediate implication or plain property, checked on every rising clock edge outside reset.
`define CRC8FR_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("crc8fr: assertion failed");

// Property whose consequence is checked in the cycle after its antecedent.
`define CRC8FR_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("crc8fr: assertion failed");

`endif

/* src/crc8fr_pkg.sv */
package crc8fr_pkg;

	localparam int BYTE_W      = 8;
	localparam int LEN_W       = 7;
	localparam int STORE_AW    = 6;
	localparam int STORE_DEPTH = 64;
	localparam int CNT_W       = 32;
	localparam int CFG_IDX_W   = 8;
	localparam int CRC_STEP_W  = 3;

	localparam logic [BYTE_W-1:0] MAX_PAYLOAD = 8'd64;
	localparam logic [BYTE_W-1:0] CRC_POLY    = 8'h07;
	localparam logic [BYTE_W-1:0] CRC_INIT    = 8'h00;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST    = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND   = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CHASSIS_COMMAND = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CHASSIS_LENGTH  = 8'd3;

	typedef enum logic [2:0] {
		PH_HEAD1,
		PH_HEAD2,
		PH_CMD,
		PH_LEN,
		PH_DATA,
		PH_CRC
	} frame_phase_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_CRC,
		SQ_READ,
		SQ_EMIT
	} seq_state_t;

	typedef struct packed {
		logic              start;
		logic [BYTE_W-1:0] seed;
	} crc_req_t;

	typedef struct packed {
		logic              done;
		logic [BYTE_W-1:0] crc;
	} crc_rsp_t;

endpackage

/* src/crc8fr_crc_unit.sv */
module crc8fr_crc_unit
	import crc8fr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  crc_req_t req,
	output crc_rsp_t rsp
);

	logic [BYTE_W-1:0]     crc_q;
	logic [CRC_STEP_W-1:0] step_q;
	logic                  busy_q;

	// One polynomial step per cycle while busy; the register keeps the running CRC between bytes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q  <= CRC_INIT;
			step_q <= '0;
			busy_q <= 1'b0;
		end else if (req.start) begin
			crc_q  <= req.seed;
			step_q <= '0;
			busy_q <= 1'b1;
		end else if (busy_q) begin
			crc_q  <= {crc_q[BYTE_W-2:0], 1'b0} ^ (crc_q[BYTE_W-1] ? CRC_POLY : '0);
			step_q <= step_q + 1'b1;
			if (step_q == '1) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign rsp.done = busy_q && (step_q == '1);
	assign rsp.crc  = crc_q;

endmodule

/* src/crc8_framed_packet_receiver_unit.sv */
// Framed packet receiver with a CRC-8 check (polynomial 0x07, initial value 0).
// Received bytes enter on the input channel (in_valid, in_stall, data_byte). The block
// hunts for the two configured header bytes, then takes a command byte, a length byte,
// up to 64 payload bytes and a CRC byte. Results leave on the output channel
// (out_valid, out_stall and one port per field): one request for a CRC mismatch or an
// empty good frame, one request per payload byte otherwise, the final one marked last.
// Header bytes and bytes that are ignored are taken without a CRC run. Command, length and
// payload bytes are each accepted and then pass through the 8 steps of the shared
// bit-serial CRC unit before the next byte is taken. A CRC byte needs no CRC run.
// A mismatch or an empty good frame then loads its single request into the output
// register as soon as it is free. A payload frame reads the payload memory before each
// of its requests, so every payload request passes a read state and then the emit state.
// No new byte is taken before the last result of a frame sits in the output register.
// Reset clears the configuration to its defaults (headers 0xAA and 0x55, chassis
// command 1, chassis length 40), zeroes the good frame counter and restarts the hunt.
// While the downstream side asserts out_stall the held request stays unchanged, and
// in_stall stays high from the CRC byte until the frame's last request has been loaded.
module crc8_framed_packet_receiver_unit
	import crc8fr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BYTE_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [BYTE_W-1:0]    data_byte,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic                 frame_ok,
	output logic [BYTE_W-1:0]    command,
	output logic [LEN_W-1:0]     payload_length,
	output logic [STORE_AW-1:0]  byte_index,
	output logic [BYTE_W-1:0]    payload_byte,
	output logic                 has_data,
	output logic                 last,
	output logic [CNT_W-1:0]     good_frame_count,
	output logic                 is_chassis
);

	// Configuration registers.
	logic [BYTE_W-1:0] hdr_first_q;
	logic [BYTE_W-1:0] hdr_second_q;
	logic [BYTE_W-1:0] chassis_cmd_q;
	logic [LEN_W-1:0]  chassis_len_q;

	// Frame state.
	seq_state_t        seq_q, seq_d;
	frame_phase_t      phase_q, phase_d;
	logic [BYTE_W-1:0] command_q;
	logic [LEN_W-1:0]  length_q;
	logic [LEN_W-1:0]  fill_q;
	logic [CNT_W-1:0]  count_q;

	// Emission state for the results of one judged frame.
	logic                emit_ok_q;
	logic                emit_data_q;
	logic                emit_chassis_q;
	logic [STORE_AW-1:0] idx_q;
	logic [BYTE_W-1:0]   mem_rd_q;

	// Payload memory; entries are always written before a good frame reads them.
	logic [BYTE_W-1:0] mem_q [STORE_DEPTH];

	// Output register.
	logic                out_valid_q;
	logic                out_ok_q;
	logic [BYTE_W-1:0]   out_cmd_q;
	logic [LEN_W-1:0]    out_len_q;
	logic [STORE_AW-1:0] out_idx_q;
	logic [BYTE_W-1:0]   out_byte_q;
	logic                out_has_q;
	logic                out_last_q;
	logic [CNT_W-1:0]    out_cnt_q;
	logic                out_chassis_q;

	// Control signals.
	logic             in_acc;
	logic             out_free;
	logic             out_load;
	logic             emit_last;
	logic             crc_match;
	logic             mem_we;
	logic [LEN_W-1:0] fill_inc;
	crc_req_t         crc_req;
	crc_rsp_t         crc_rsp;

	// The shared bit-serial CRC unit; it also holds the running CRC between bytes.
	crc8fr_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (crc_req),
		.rsp    (crc_rsp)
	);

	// Next state of the sequencer and of the frame parser.
	always_comb begin
		seq_d   = seq_q;
		phase_d = phase_q;
		unique case (seq_q)
			SQ_IDLE: begin
				if (in_acc) begin
					unique case (phase_q)
						PH_HEAD1: begin
							if (data_byte == hdr_first_q) begin
								phase_d = PH_HEAD2;
							end
						end
						PH_HEAD2: begin
							// A repeated first header byte keeps the hunt alive.
							if (data_byte == hdr_second_q) begin
								phase_d = PH_CMD;
							end else if (data_byte != hdr_first_q) begin
								phase_d = PH_HEAD1;
							end
						end
						PH_CMD: begin
							phase_d = PH_LEN;
							seq_d   = SQ_CRC;
						end
						PH_LEN: begin
							seq_d = SQ_CRC;
							// An oversized length drops the frame without a result.
							if (data_byte == '0) begin
								phase_d = PH_CRC;
							end else if (data_byte <= MAX_PAYLOAD) begin
								phase_d = PH_DATA;
							end else begin
								phase_d = PH_HEAD1;
							end
						end
						PH_DATA: begin
							seq_d = SQ_CRC;
							if (fill_inc >= length_q) begin
								phase_d = PH_CRC;
							end
						end
						PH_CRC: begin
							phase_d = PH_HEAD1;
							if (!crc_match || length_q == '0) begin
								seq_d = SQ_EMIT;
							end else begin
								seq_d = SQ_READ;
							end
						end
						default: begin
							phase_d = PH_HEAD1;
						end
					endcase
				end
			end
			SQ_CRC: begin
				if (crc_rsp.done) begin
					seq_d = SQ_IDLE;
				end
			end
			SQ_READ: begin
				seq_d = SQ_EMIT;
			end
			SQ_EMIT: begin
				if (out_free) begin
					seq_d = emit_last ? SQ_IDLE : SQ_READ;
				end
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		in_acc        = in_valid && (seq_q == SQ_IDLE);
		fill_inc      = fill_q + 1'b1;
		crc_match     = (crc_rsp.crc == data_byte);
		crc_req.start = in_acc && (phase_q == PH_CMD || phase_q == PH_LEN ||
			phase_q == PH_DATA);
		crc_req.seed  = ((phase_q == PH_CMD) ? CRC_INIT : crc_rsp.crc) ^ data_byte;
		mem_we        = in_acc && (phase_q == PH_DATA);
		out_free      = !out_valid_q || !out_stall;
		out_load      = (seq_q == SQ_EMIT) && out_free;
		emit_last     = !emit_data_q || ({1'b0, idx_q} + 1'b1 == length_q);
	end

	// Control registers and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_first_q   <= 8'hAA;
			hdr_second_q  <= 8'h55;
			chassis_cmd_q <= 8'd1;
			chassis_len_q <= 7'd40;
			seq_q         <= SQ_IDLE;
			phase_q       <= PH_HEAD1;
			command_q     <= '0;
			length_q      <= '0;
			fill_q        <= '0;
			count_q       <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			seq_q   <= seq_d;
			phase_q <= phase_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_HEADER_FIRST:    hdr_first_q   <= cfg_data;
					CFG_HEADER_SECOND:   hdr_second_q  <= cfg_data;
					CFG_CHASSIS_COMMAND: chassis_cmd_q <= cfg_data;
					CFG_CHASSIS_LENGTH:  chassis_len_q <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				unique case (phase_q)
					PH_CMD: command_q <= data_byte;
					PH_LEN: begin
						length_q <= data_byte[LEN_W-1:0];
						fill_q   <= '0;
					end
					PH_DATA: fill_q <= fill_inc;
					PH_CRC: begin
						if (crc_match) begin
							count_q <= count_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Emission bookkeeping and the output register.
	always_ff @(posedge clk) begin
		if (in_acc && phase_q == PH_CRC) begin
			emit_ok_q      <= crc_match;
			emit_data_q    <= crc_match && (length_q != '0);
			emit_chassis_q <= crc_match && (command_q == chassis_cmd_q) &&
				(length_q == chassis_len_q);
			idx_q          <= '0;
		end else if (out_load && !emit_last) begin
			idx_q <= idx_q + 1'b1;
		end
		if (out_load) begin
			out_ok_q      <= emit_ok_q;
			out_cmd_q     <= command_q;
			out_len_q     <= length_q;
			out_idx_q     <= emit_data_q ? idx_q : '0;
			out_byte_q    <= emit_data_q ? mem_rd_q : '0;
			out_has_q     <= emit_data_q;
			out_last_q    <= emit_last;
			out_cnt_q     <= count_q;
			out_chassis_q <= emit_chassis_q;
		end
	end

	// Payload memory: one write port on payload byte accept, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[fill_q[STORE_AW-1:0]] <= data_byte;
		end
		if (seq_q == SQ_READ) begin
			mem_rd_q <= mem_q[idx_q];
		end
	end

	assign in_stall         = (seq_q != SQ_IDLE);
	assign out_valid        = out_valid_q;
	assign frame_ok         = out_ok_q;
	assign command          = out_cmd_q;
	assign payload_length   = out_len_q;
	assign byte_index       = out_idx_q;
	assign payload_byte     = out_byte_q;
	assign has_data         = out_has_q;
	assign last             = out_last_q;
	assign good_frame_count = out_cnt_q;
	assign is_chassis       = out_chassis_q;

endmodule

/* src/crc8fr_checker.sv */
`include "crc8_framed_packet_receiver_unit_defines.svh"

module crc8fr_checker
	import crc8fr_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 frame_ok,
	input logic [STORE_AW-1:0]  byte_index,
	input logic [BYTE_W-1:0]    payload_byte,
	input logic                 has_data,
	input logic                 last,
	input logic                 is_chassis
);

	// A mismatch request is a lone, empty, final request.
	`CRC8FR_ASSERT(a_mismatch_shape, clk, arst_n, out_valid && !frame_ok |-> last && !has_data && !is_chassis)

	// A request without payload always closes its frame.
	`CRC8FR_ASSERT(a_empty_is_last, clk, arst_n, out_valid && !has_data |-> last)

	// Payload bytes only leave for frames that passed the check.
	`CRC8FR_ASSERT(a_data_needs_ok, clk, arst_n, out_valid && has_data |-> frame_ok)

	// A stalled request stays put.
	`CRC8FR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(byte_index) && $stable(payload_byte) && $stable(last))

endmodule

bind crc8_framed_packet_receiver_unit crc8fr_checker u_crc8fr_checker (.*);
